/* sv/bld_pkg.sv */
// ----------------------------------------------------------------------------
// bld_pkg
// Shared widths, register codes and types for the block-linear deswizzle
// address generator.
// ----------------------------------------------------------------------------
`default_nettype none

package bld_pkg;

  // Channel and register widths
  localparam int XY_W       = 16;
  localparam int ADDR_W     = 32;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int DIM_W      = 16;
  localparam int BDL_W      = 2;
  localparam int BPE_W      = 5;
  localparam int GHL_W      = 3;

  // Internal widths, sized to the largest value each can carry
  localparam int XB_W    = XY_W + BPE_W;        // x * bpe
  localparam int WB_W    = XB_W + 1;            // row bytes, rounded up
  localparam int HR_W    = DIM_W + 1;           // rows, rounded up to a block
  localparam int GW_W    = XB_W - 6;            // GOBs per row
  localparam int ROWB_W  = XY_W - 3;            // block row index
  localparam int YMID_W  = 7;                   // GOB index inside a block
  localparam int GPROD_W = ROWB_W + GW_W;
  localparam int BMASK_W = 4;                   // block edge mask, up to 7
  localparam int RMASK_W = 11;                  // row mask, up to 1023

  // GOB geometry: 64 bytes by 8 rows, 512 bytes
  localparam int GOB_BYTES_LOG2 = 9;
  localparam int GOB_ROWS_LOG2  = 3;
  localparam int GOB_WIDE_LOG2  = 6;
  localparam logic [WB_W-1:0] LIN_ALIGN_MASK = WB_W'(31);
  localparam logic [WB_W-1:0] GOB_ALIGN_MASK = WB_W'(63);

  localparam int NUM_STAGES = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH   = 3'd0,
    CFG_IMAGE_HEIGHT  = 3'd1,
    CFG_BLOCK_DIM     = 3'd2,
    CFG_BYTES_PER_EL  = 3'd3,
    CFG_LINEAR_MODE   = 3'd4,
    CFG_ROUND_PITCH   = 3'd5,
    CFG_GOB_HEIGHT    = 3'd6,
    CFG_SOURCE_SIZE   = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [DIM_W-1:0]  image_width;
    logic [DIM_W-1:0]  image_height;
    logic [BDL_W-1:0]  block_dim_log2;
    logic [BPE_W-1:0]  bytes_per_element;
    logic              linear_mode;
    logic              round_pitch;
    logic [GHL_W-1:0]  gob_height_log2;
    logic [ADDR_W-1:0] source_size;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    image_width:       DIM_W'(1),
    image_height:      DIM_W'(1),
    block_dim_log2:    BDL_W'(2),
    bytes_per_element: BPE_W'(8),
    linear_mode:       1'b0,
    round_pitch:       1'b0,
    gob_height_log2:   GHL_W'(4),
    source_size:       '0
  };

  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
  } pipe_ctl_t;

  // Round up to a power-of-two multiple given as mask (m - 1); zero stays zero
  function automatic logic [WB_W-1:0] round_up_mask(input logic [WB_W-1:0] v,
                                                    input logic [WB_W-1:0] mask);
    logic [WB_W-1:0] r;
    if (v == '0) begin
      r = '0;
    end else begin
      r = ((v - WB_W'(1)) | mask) + WB_W'(1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* sv/bld_in_if.sv */
// ----------------------------------------------------------------------------
// bld_in_if
// Coordinate channel: one element position per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface bld_in_if import bld_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [XY_W-1:0] x_block;
  logic [XY_W-1:0] y_block;

  modport source (output valid, output x_block, output y_block, input ready);
  modport sink   (input valid, input x_block, input y_block, output ready);
endinterface

`default_nettype wire

/* sv/bld_out_if.sv */
// ----------------------------------------------------------------------------
// bld_out_if
// Address channel: source address, destination address and copy flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface bld_out_if import bld_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] src_addr;
  logic [ADDR_W-1:0] dst_addr;
  logic              copy_valid;

  modport source (output valid, output src_addr, output dst_addr, output copy_valid,
                  input ready);
  modport sink   (input valid, input src_addr, input dst_addr, input copy_valid,
                  output ready);
endinterface

`default_nettype wire

/* sv/bld_cfg_regs.sv */
// ----------------------------------------------------------------------------
// bld_cfg_regs
// Configuration register file, written by index.
// ----------------------------------------------------------------------------
`default_nettype none

module bld_cfg_regs import bld_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_IMAGE_WIDTH:  cfg_d.image_width       = cfg_wdata_i[DIM_W-1:0];
        CFG_IMAGE_HEIGHT: cfg_d.image_height      = cfg_wdata_i[DIM_W-1:0];
        CFG_BLOCK_DIM:    cfg_d.block_dim_log2    = cfg_wdata_i[BDL_W-1:0];
        CFG_BYTES_PER_EL: cfg_d.bytes_per_element = cfg_wdata_i[BPE_W-1:0];
        CFG_LINEAR_MODE:  cfg_d.linear_mode       = cfg_wdata_i[0];
        CFG_ROUND_PITCH:  cfg_d.round_pitch       = cfg_wdata_i[0];
        CFG_GOB_HEIGHT:   cfg_d.gob_height_log2   = cfg_wdata_i[GHL_W-1:0];
        CFG_SOURCE_SIZE:  cfg_d.source_size       = cfg_wdata_i[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* sv/bld_pipe_ctrl.sv */
// ----------------------------------------------------------------------------
// bld_pipe_ctrl
// Per-stage valid bits and load enables. A stage loads when it is empty or
// when the stage after it loads, so bubbles close up under a stall.
// ----------------------------------------------------------------------------
`default_nettype none

module bld_pipe_ctrl import bld_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output pipe_ctl_t ctl_o
);

  logic [NUM_STAGES-1:0] valid_q, valid_d;
  logic [NUM_STAGES-1:0] load;

  always_comb begin
    load[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || out_ready_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      load[k] = !valid_q[k] || load[k+1];
    end
  end

  always_comb begin
    valid_d[0] = load[0] ? in_valid_i : valid_q[0];
    for (int k = 1; k < NUM_STAGES; k++) begin
      valid_d[k] = load[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o   = load[0];
  assign out_valid_o  = valid_q[NUM_STAGES-1];
  assign ctl_o.load   = load;

endmodule

`default_nettype wire

/* sv/bld_addr_dp.sv */
// ----------------------------------------------------------------------------
// bld_addr_dp
// Six-stage address datapath: block counts, row bytes, pitch and rounding,
// products, source address assembly, bounds test.
// ----------------------------------------------------------------------------
`default_nettype none

module bld_addr_dp import bld_pkg::*; (
  input  logic              clk_i,
  input  cfg_t              cfg_i,
  input  pipe_ctl_t         ctl_i,
  input  logic [XY_W-1:0]   x_block_i,
  input  logic [XY_W-1:0]   y_block_i,
  output logic [ADDR_W-1:0] src_addr_o,
  output logic [ADDR_W-1:0] dst_addr_o,
  output logic              copy_valid_o
);

  localparam int YW_W     = 2 * XY_W;
  localparam int LIN_W    = XY_W + WB_W;
  localparam int SURF_W   = WB_W + HR_W;
  localparam int DST_W    = ADDR_W + BPE_W;
  localparam int SUM_W    = DIM_W + 1;

  logic [BPE_W-1:0] bpe;
  assign bpe = cfg_i.bytes_per_element;

  // ---------------- stage 1: element counts, x bytes ----------------
  logic [BMASK_W-1:0] blk_mask;
  logic [SUM_W-1:0]   w_sum, h_sum;
  logic [DIM_W-1:0]   s1_w_q, s1_h_q;
  logic [XY_W-1:0]    s1_x_q, s1_y_q;
  logic [XB_W-1:0]    s1_xb_q;

  assign blk_mask = (BMASK_W'(1) << cfg_i.block_dim_log2) - BMASK_W'(1);
  assign w_sum    = SUM_W'(cfg_i.image_width) + SUM_W'(blk_mask);
  assign h_sum    = SUM_W'(cfg_i.image_height) + SUM_W'(blk_mask);

  always_ff @(posedge clk_i) begin
    if (ctl_i.load[0]) begin
      s1_w_q  <= DIM_W'(w_sum >> cfg_i.block_dim_log2);
      s1_h_q  <= DIM_W'(h_sum >> cfg_i.block_dim_log2);
      s1_x_q  <= x_block_i;
      s1_y_q  <= y_block_i;
      s1_xb_q <= XB_W'(x_block_i) * XB_W'(bpe);
    end
  end

  // ---------------- stage 2: row bytes, y * W ----------------
  logic [XB_W-1:0]  s2_wb_q, s2_xb_q;
  logic [YW_W-1:0]  s2_yw_q;
  logic [DIM_W-1:0] s2_h_q;
  logic [XY_W-1:0]  s2_x_q, s2_y_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load[1]) begin
      s2_wb_q <= XB_W'(s1_w_q) * XB_W'(bpe);
      s2_yw_q <= YW_W'(s1_y_q) * YW_W'(s1_w_q);
      s2_h_q  <= s1_h_q;
      s2_x_q  <= s1_x_q;
      s2_y_q  <= s1_y_q;
      s2_xb_q <= s1_xb_q;
    end
  end

  // ---------------- stage 3: pitch, padded height, GOB split ----------------
  logic [GHL_W+1-1:0]  row_shift;
  logic [RMASK_W-1:0]  row_mask;
  logic [YMID_W-1:0]   gob_mask;
  logic [WB_W-1:0]     wb_ext, pitch_c, hr_c, gw_sum;
  logic [XY_W-1:0]     y_gob;

  logic [WB_W-1:0]     s3_pitch_q;
  logic [HR_W-1:0]     s3_hr_q;
  logic [GW_W-1:0]     s3_gw_q;
  logic [ADDR_W-1:0]   s3_dsum_q;
  logic [ROWB_W-1:0]   s3_rowb_q;
  logic [YMID_W-1:0]   s3_ymid_q;
  logic [XY_W-1:0]     s3_y_q;
  logic [XB_W-1:0]     s3_xb_q;

  assign row_shift = (GHL_W+1)'(cfg_i.gob_height_log2) + (GHL_W+1)'(GOB_ROWS_LOG2);
  assign row_mask  = (RMASK_W'(1) << row_shift) - RMASK_W'(1);
  assign gob_mask  = YMID_W'((8'd1 << cfg_i.gob_height_log2) - 8'd1);
  assign wb_ext    = WB_W'(s2_wb_q);
  assign gw_sum    = wb_ext + GOB_ALIGN_MASK;
  assign y_gob     = s2_y_q >> GOB_ROWS_LOG2;

  always_comb begin
    if (cfg_i.linear_mode) begin
      pitch_c = cfg_i.round_pitch ? round_up_mask(wb_ext, LIN_ALIGN_MASK) : wb_ext;
      hr_c    = WB_W'(s2_h_q);
    end else begin
      pitch_c = round_up_mask(wb_ext, GOB_ALIGN_MASK);
      hr_c    = round_up_mask(WB_W'(s2_h_q), WB_W'(row_mask));
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load[2]) begin
      s3_pitch_q <= pitch_c;
      s3_hr_q    <= hr_c[HR_W-1:0];
      s3_gw_q    <= gw_sum[GOB_WIDE_LOG2 +: GW_W];
      s3_dsum_q  <= s2_yw_q + ADDR_W'(s2_x_q);
      s3_rowb_q  <= ROWB_W'(s2_y_q >> row_shift);
      s3_ymid_q  <= YMID_W'(y_gob) & gob_mask;
      s3_y_q     <= s2_y_q;
      s3_xb_q    <= s2_xb_q;
    end
  end

  // ---------------- stage 4: products ----------------
  logic [LIN_W-1:0]   lin_full;
  logic [SURF_W-1:0]  surf_full;
  logic [DST_W-1:0]   dst_full;

  logic [ADDR_W-1:0]  s4_lin_q, s4_surface_q, s4_dst_q;
  logic [GPROD_W-1:0] s4_gprod_q;
  logic [YMID_W-1:0]  s4_ymid_q;
  logic [XY_W-1:0]    s4_y_q;
  logic [XB_W-1:0]    s4_xb_q;

  assign lin_full  = LIN_W'(s3_y_q) * LIN_W'(s3_pitch_q);
  assign surf_full = SURF_W'(s3_pitch_q) * SURF_W'(s3_hr_q);
  assign dst_full  = DST_W'(s3_dsum_q) * DST_W'(bpe);

  always_ff @(posedge clk_i) begin
    if (ctl_i.load[3]) begin
      s4_lin_q     <= lin_full[ADDR_W-1:0];
      s4_surface_q <= surf_full[ADDR_W-1:0];
      s4_dst_q     <= dst_full[ADDR_W-1:0];
      s4_gprod_q   <= GPROD_W'(s3_rowb_q) * GPROD_W'(s3_gw_q);
      s4_ymid_q    <= s3_ymid_q;
      s4_y_q       <= s3_y_q;
      s4_xb_q      <= s3_xb_q;
    end
  end

  // ---------------- stage 5: source address ----------------
  // Whole-GOB offset sits above bit 9+log2(bh); GOB-in-block index above
  // bit 9; the byte inside the GOB packs into the low nine bits.
  logic [GHL_W+2-1:0] blk_shift;
  logic [ADDR_W-1:0]  gob_index, blk_addr, src_c;
  logic [GOB_BYTES_LOG2-1:0] in_gob;

  logic [ADDR_W-1:0]  s5_src_q, s5_dst_q, s5_surface_q;

  assign blk_shift = (GHL_W+2)'(cfg_i.gob_height_log2) + (GHL_W+2)'(GOB_BYTES_LOG2);
  assign gob_index = ADDR_W'(s4_gprod_q) + ADDR_W'(s4_xb_q >> GOB_WIDE_LOG2);
  assign in_gob    = {s4_xb_q[5], s4_y_q[2:1], s4_xb_q[4], s4_y_q[0], s4_xb_q[3:0]};
  assign blk_addr  = (gob_index << blk_shift)
                   | (ADDR_W'(s4_ymid_q) << GOB_BYTES_LOG2)
                   | ADDR_W'(in_gob);
  assign src_c     = cfg_i.linear_mode ? (s4_lin_q + ADDR_W'(s4_xb_q)) : blk_addr;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load[4]) begin
      s5_src_q     <= src_c;
      s5_dst_q     <= s4_dst_q;
      s5_surface_q <= s4_surface_q;
    end
  end

  // ---------------- stage 6: bounds test, output register ----------------
  logic [ADDR_W:0]   elem_end;
  logic [ADDR_W-1:0] s6_src_q, s6_dst_q;
  logic              s6_ok_q;

  assign elem_end = {1'b0, s5_src_q} + (ADDR_W+1)'(bpe);

  always_ff @(posedge clk_i) begin
    if (ctl_i.load[5]) begin
      s6_src_q <= s5_src_q;
      s6_dst_q <= s5_dst_q;
      s6_ok_q  <= (elem_end <= {1'b0, s5_surface_q})
               && (elem_end <= {1'b0, cfg_i.source_size});
    end
  end

  assign src_addr_o   = s6_src_q;
  assign dst_addr_o   = s6_dst_q;
  assign copy_valid_o = s6_ok_q;

endmodule

`default_nettype wire

/* sv/block_linear_deswizzle_addr.sv */
// ----------------------------------------------------------------------------
// block_linear_deswizzle_addr
// Element address generator for block-linear (GOB) and pitch-linear
// surfaces: source address, packed destination address and copy flag.
//
//   channel  dir  handshake     payload
//   in_i     in   valid/ready   x_block, y_block
//   out_o    out  valid/ready   src_addr, dst_addr, copy_valid
//   cfg      in   cfg_we_i      cfg_idx_i, cfg_wdata_i (write only)
//
// One element per clock sustained while out_o is ready; each element passes
// through every datapath register stage (the 22x17 surface product stage sets the clock).
// Reset clears the stage valid bits and loads register defaults.
// A stall at out_o holds the last stage; earlier stages keep filling until
// each is occupied, then in_i.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module block_linear_deswizzle_addr import bld_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  bld_in_if.sink                in_i,
  bld_out_if.source             out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  cfg_t      cfg;
  pipe_ctl_t ctl;

  bld_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  bld_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .ctl_o       (ctl)
  );

  bld_addr_dp u_dp (
    .clk_i        (clk_i),
    .cfg_i        (cfg),
    .ctl_i        (ctl),
    .x_block_i    (in_i.x_block),
    .y_block_i    (in_i.y_block),
    .src_addr_o   (out_o.src_addr),
    .dst_addr_o   (out_o.dst_addr),
    .copy_valid_o (out_o.copy_valid)
  );

endmodule

`default_nettype wire

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for block_linear_deswizzle_addr. A directed table runs
// first: reset defaults, field extremes and the corner cases of the address
// math. Randomized phases follow, each with its own register setup and
// handshake idling. Every address transfer is checked against the table's
// expected value for known rows, else against a local address predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import bld_pkg::*;

  localparam int CLK_PERIOD    = 8;
  localparam int RESET_CYCLES  = 5;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS   = 96;
  localparam int HOLD_PHASE    = 4;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_CYCLES  = 20;
  localparam int CYCLE_LIMIT   = 200000;

  typedef struct packed {
    logic [ADDR_W-1:0] src_addr;
    logic [ADDR_W-1:0] dst_addr;
    logic              copy_valid;
  } addr_result_t;

  typedef enum logic {ROW_CFG, ROW_ELEM} row_kind_e;

  typedef struct {
    row_kind_e             kind;
    cfg_idx_e              reg_idx;
    logic [CFG_DATA_W-1:0] value;
    logic [XY_W-1:0]       x;
    logic [XY_W-1:0]       y;
    bit                    known;
    addr_result_t          expected;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  cfg_idx_e              cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  bld_in_if  coord_ch ();
  bld_out_if addr_ch ();

  cfg_t          shadow_cfg = CFG_RESET;
  addr_result_t  pending_addrs[$];
  plan_row_t     directed_plan[$];
  int            error_count  = 0;
  int            cycle_count  = 0;
  int            send_idle_pct = 0;
  int            stall_pct     = 0;
  bit            hold_off_req  = 1'b0;

  block_linear_deswizzle_addr u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_i        (coord_ch),
    .out_o       (addr_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // --------------------------------------------------------------------------
  // Address predictor
  // --------------------------------------------------------------------------
  function automatic int unsigned align_up(input int unsigned v, input int unsigned m);
    return ((v - 1) | (m - 1)) + 1;
  endfunction

  // texels to compressed blocks, rounded up
  function automatic int unsigned blocks_across(input logic [DIM_W-1:0] dim);
    return (32'(dim) + (32'd1 << shadow_cfg.block_dim_log2) - 32'd1)
           >> shadow_cfg.block_dim_log2;
  endfunction

  function automatic int unsigned row_pitch(input int unsigned w);
    int unsigned p;
    p = w * shadow_cfg.bytes_per_element;
    if (shadow_cfg.linear_mode) begin
      if (shadow_cfg.round_pitch) p = align_up(p, 32);
    end else begin
      p = align_up(p, 64);
    end
    return p;
  endfunction

  function automatic int unsigned surface_size();
    int unsigned w, h, pitch;
    w = blocks_across(shadow_cfg.image_width);
    h = blocks_across(shadow_cfg.image_height);
    pitch = row_pitch(w);
    if (shadow_cfg.linear_mode) return pitch * h;
    return pitch * align_up(h, (32'd1 << shadow_cfg.gob_height_log2) * 8);
  endfunction

  function automatic addr_result_t predict_element_addrs(input logic [XY_W-1:0] x,
                                                         input logic [XY_W-1:0] y);
    int unsigned   xu, yu, w, bpe, bh, rows_per_block, xb, gobs_wide, src;
    logic [ADDR_W:0] end_byte;
    addr_result_t  r;
    xu  = 32'(x);
    yu  = 32'(y);
    bpe = 32'(shadow_cfg.bytes_per_element);
    w   = blocks_across(shadow_cfg.image_width);
    if (shadow_cfg.linear_mode) begin
      src = yu * row_pitch(w) + xu * bpe;
    end else begin
      // 64 B x 8 row GOBs, bh GOBs stacked per block
      bh             = 32'd1 << shadow_cfg.gob_height_log2;
      rows_per_block = 8 * bh;
      xb             = xu * bpe;
      gobs_wide      = (w * bpe + 63) / 64;
      src = (yu / rows_per_block) * 512 * bh * gobs_wide
          + (xb / 64) * 512 * bh
          + ((yu % rows_per_block) / 8) * 512
          + ((xb % 64) / 32) * 256 + ((yu % 8) / 2) * 64
          + ((xb % 32) / 16) * 32 + (yu % 2) * 16 + xb % 16;
    end
    r.src_addr = src;
    r.dst_addr = (yu * w + xu) * bpe;
    // end of element is formed without wrap
    end_byte = {1'b0, src} + {1'b0, bpe};
    r.copy_valid = (end_byte <= {1'b0, surface_size()}) &&
                   (end_byte <= {1'b0, shadow_cfg.source_size});
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic plan_row_t cfg_row(input cfg_idx_e idx, input logic [31:0] value);
    plan_row_t r;
    r = '{ROW_CFG, idx, value, '0, '0, 1'b0, '0};
    return r;
  endfunction

  function automatic plan_row_t elem_row(input logic [XY_W-1:0] x, input logic [XY_W-1:0] y);
    plan_row_t r;
    r = '{ROW_ELEM, CFG_IMAGE_WIDTH, '0, x, y, 1'b0, '0};
    return r;
  endfunction

  function automatic plan_row_t known_row(input logic [XY_W-1:0] x, input logic [XY_W-1:0] y,
                                          input logic [ADDR_W-1:0] src,
                                          input logic [ADDR_W-1:0] dst, input logic ok);
    plan_row_t r;
    r = '{ROW_ELEM, CFG_IMAGE_WIDTH, '0, x, y, 1'b1, '{src, dst, ok}};
    return r;
  endfunction

  // garbage above the register width now and then
  function automatic logic [CFG_DATA_W-1:0] noisy(input logic [CFG_DATA_W-1:0] v,
                                                   input int bits);
    if ($urandom_range(1)) return v | ($urandom() << bits);
    return v;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_dim();
    case ($urandom_range(9))
      0:       return 0;
      1:       return 65535;
      2:       return 1;
      default: return $urandom_range(600, 1);
    endcase
  endfunction

  // mostly inside the surface, the rest anywhere in the 16-bit range
  function automatic logic [XY_W-1:0] pick_coord(input int unsigned extent);
    if (extent != 0 && $urandom_range(3) != 0) return XY_W'($urandom_range(extent - 1, 0));
    return XY_W'($urandom());
  endfunction

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_IMAGE_WIDTH:  shadow_cfg.image_width       = value[DIM_W-1:0];
      CFG_IMAGE_HEIGHT: shadow_cfg.image_height      = value[DIM_W-1:0];
      CFG_BLOCK_DIM:    shadow_cfg.block_dim_log2    = value[BDL_W-1:0];
      CFG_BYTES_PER_EL: shadow_cfg.bytes_per_element = value[BPE_W-1:0];
      CFG_LINEAR_MODE:  shadow_cfg.linear_mode       = value[0];
      CFG_ROUND_PITCH:  shadow_cfg.round_pitch       = value[0];
      CFG_GOB_HEIGHT:   shadow_cfg.gob_height_log2   = value[GHL_W-1:0];
      CFG_SOURCE_SIZE:  shadow_cfg.source_size       = value[ADDR_W-1:0];
      default: ;
    endcase
  endtask

  // entered and left at a falling edge; valid stays up for a following item
  task automatic send_coord(input logic [XY_W-1:0] x, input logic [XY_W-1:0] y,
                            input bit known, input addr_result_t expected);
    while ($urandom_range(99) < send_idle_pct) begin
      coord_ch.valid <= 1'b0;
      @(negedge clk);
    end
    coord_ch.valid   <= 1'b1;
    coord_ch.x_block <= x;
    coord_ch.y_block <= y;
    do @(posedge clk); while (!coord_ch.ready);
    if (known) pending_addrs.push_back(expected);
    else       pending_addrs.push_back(predict_element_addrs(x, y));
    @(negedge clk);
  endtask

  task automatic wait_idle();
    coord_ch.valid <= 1'b0;
    while (pending_addrs.size() != 0) @(negedge clk);
  endtask

  task automatic setup_random_phase();
    int unsigned surf;
    write_reg(CFG_IMAGE_WIDTH,  noisy(pick_dim(), DIM_W));
    write_reg(CFG_IMAGE_HEIGHT, noisy(pick_dim(), DIM_W));
    write_reg(CFG_BLOCK_DIM,    noisy($urandom_range(3), BDL_W));
    if ($urandom_range(3) == 0) write_reg(CFG_BYTES_PER_EL, noisy($urandom_range(31), BPE_W));
    else                        write_reg(CFG_BYTES_PER_EL, 32'd1 << $urandom_range(4));
    write_reg(CFG_LINEAR_MODE,  noisy($urandom_range(1), 1));
    write_reg(CFG_ROUND_PITCH,  noisy($urandom_range(1), 1));
    write_reg(CFG_GOB_HEIGHT,   noisy($urandom_range(7), GHL_W));
    // place the source size around the surface so the copy flag toggles
    surf = surface_size();
    case ($urandom_range(3))
      0:       write_reg(CFG_SOURCE_SIZE, surf);
      1:       write_reg(CFG_SOURCE_SIZE, 32'hFFFF_FFFF);
      2:       write_reg(CFG_SOURCE_SIZE, $urandom());
      default: write_reg(CFG_SOURCE_SIZE, surf - $urandom_range(4096));
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    error_count++;
  endtask

  // --------------------------------------------------------------------------
  // Result checking, receiver and watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    addr_result_t exp_addrs;
    if (rst_n && addr_ch.valid && addr_ch.ready) begin
      if (pending_addrs.size() == 0) begin
        report_mismatch($sformatf("unexpected transfer src=%h dst=%h flag=%b",
                                  addr_ch.src_addr, addr_ch.dst_addr, addr_ch.copy_valid));
      end else begin
        exp_addrs = pending_addrs.pop_front();
        if (addr_ch.src_addr !== exp_addrs.src_addr)
          report_mismatch($sformatf("src_addr got %h exp %h",
                                    addr_ch.src_addr, exp_addrs.src_addr));
        if (addr_ch.dst_addr !== exp_addrs.dst_addr)
          report_mismatch($sformatf("dst_addr got %h exp %h",
                                    addr_ch.dst_addr, exp_addrs.dst_addr));
        if (addr_ch.copy_valid !== exp_addrs.copy_valid)
          report_mismatch($sformatf("copy_valid got %b exp %b",
                                    addr_ch.copy_valid, exp_addrs.copy_valid));
      end
    end
  end

  initial begin
    addr_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        // long back-pressure so the pipeline fills and input ready drops
        addr_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end else begin
        addr_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    plan_row_t   row;
    int unsigned w_blocks, h_blocks;
    rst_n            = 1'b0;
    coord_ch.valid   = 1'b0;
    coord_ch.x_block = '0;
    coord_ch.y_block = '0;
    cfg_we           = 1'b0;
    cfg_idx          = CFG_IMAGE_WIDTH;
    cfg_wdata        = '0;

    directed_plan = '{
      // reset defaults: 1x1 texels, 8 B elements, 16-GOB blocks, no source
      known_row(16'd0, 16'd0, 32'd0,  32'd0, 1'b0),
      known_row(16'd1, 16'd0, 32'd8,  32'd8, 1'b0),
      known_row(16'd0, 16'd1, 32'd16, 32'd8, 1'b0),
      elem_row(16'hFFFF, 16'hFFFF),
      cfg_row(CFG_SOURCE_SIZE, 32'hFFFF_FFFF),
      known_row(16'd0, 16'd0, 32'd0,  32'd0, 1'b1),
      elem_row(16'd15, 16'd127),
      elem_row(16'h8000, 16'h0001),
      // largest surface, widest element, tallest blocks: products wrap
      cfg_row(CFG_IMAGE_WIDTH,  32'd65535),
      cfg_row(CFG_IMAGE_HEIGHT, 32'd65535),
      cfg_row(CFG_BLOCK_DIM,    32'd0),
      cfg_row(CFG_BYTES_PER_EL, 32'd31),
      cfg_row(CFG_GOB_HEIGHT,   32'd7),
      elem_row(16'hFFFF, 16'hFFFF),
      elem_row(16'd0, 16'd0),
      elem_row(16'd300, 16'd1000),
      // zero-byte elements
      cfg_row(CFG_BYTES_PER_EL, 32'd0),
      elem_row(16'd5, 16'd5),
      cfg_row(CFG_BYTES_PER_EL, 32'd16),
      cfg_row(CFG_GOB_HEIGHT,   32'd0),
      cfg_row(CFG_BLOCK_DIM,    32'd3),
      elem_row(16'd8191, 16'd8191),
      elem_row(16'd1, 16'd9),
      // pitch linear, unrounded then rounded, coordinate past the width
      cfg_row(CFG_LINEAR_MODE,  32'd1),
      cfg_row(CFG_ROUND_PITCH,  32'd0),
      cfg_row(CFG_IMAGE_WIDTH,  32'd10),
      cfg_row(CFG_IMAGE_HEIGHT, 32'd10),
      cfg_row(CFG_BYTES_PER_EL, 32'd3),
      elem_row(16'd9, 16'd9),
      elem_row(16'd10, 16'd0),
      cfg_row(CFG_ROUND_PITCH,  32'd1),
      elem_row(16'd9, 16'd9),
      // zero width: pitch stays zero after rounding
      cfg_row(CFG_IMAGE_WIDTH,  32'd0),
      elem_row(16'd0, 16'd0),
      elem_row(16'd3, 16'd2),
      cfg_row(CFG_LINEAR_MODE,  32'd0),
      elem_row(16'd1, 16'd1),
      // source size larger than the surface, so the surface bound decides
      cfg_row(CFG_IMAGE_WIDTH,  32'd100),
      cfg_row(CFG_IMAGE_HEIGHT, 32'd40),
      cfg_row(CFG_SOURCE_SIZE,  32'd2048),
      elem_row(16'd0, 16'd0),
      elem_row(16'd20, 16'd7),
      elem_row(16'd24, 16'd33)
    };

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_plan[i]) begin
      row = directed_plan[i];
      if (row.kind == ROW_CFG) begin
        wait_idle();
        write_reg(row.reg_idx, row.value);
      end else begin
        send_coord(row.x, row.y, row.known, row.expected);
      end
    end

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_idle();
      setup_random_phase();
      case (phase % 4)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 52; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 52; end
        default: begin send_idle_pct = 6;  stall_pct = 6;  end
      endcase
      if (phase == HOLD_PHASE) hold_off_req = 1'b1;
      w_blocks = blocks_across(shadow_cfg.image_width);
      h_blocks = blocks_across(shadow_cfg.image_height);
      repeat (PHASE_ITEMS)
        send_coord(pick_coord(w_blocks), pick_coord(h_blocks), 1'b0, '0);
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/bld_pkg.sv
sv/bld_in_if.sv
sv/bld_out_if.sv
sv/bld_cfg_regs.sv
sv/bld_pipe_ctrl.sv
sv/bld_addr_dp.sv
sv/block_linear_deswizzle_addr.sv
tb/testbench.sv
